// ===== hdl/bsfr_pkg.sv =====
// ---------------------------------------------------------------------------
// bsfr_pkg
// Shared types, constants and helpers for the byte stream find/replace block.
// ---------------------------------------------------------------------------
package bsfr_pkg;

    localparam int MAX_PATTERN_BYTES = 8;
    localparam int FILL_W            = 4;   // holds 0..MAX_PATTERN_BYTES
    localparam int WIN_IDX_W         = 3;   // indexes the window slots
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int COUNT_W           = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_PATTERN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LIMIT       = 3'd4;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] t_win;

    typedef struct packed {
        logic [63:0]  search_pattern;
        logic [3:0]   search_length;
        logic [63:0]  replacement_pattern;
        logic [3:0]   replacement_length;
        logic [16:0]  replace_limit;     // bit 16 set: no limit
    } t_cfg;

    // one queued job: emit cnt bytes of data, lowest byte first
    typedef struct packed {
        t_win              data;
        logic [FILL_W-1:0] cnt;
        logic              last;         // cnt == 0 with last: bare end marker
    } t_cmd;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } t_fr_stat;

    function automatic logic [FILL_W-1:0] clamp_len(input logic [3:0] v);
        return (v > FILL_W'(MAX_PATTERN_BYTES)) ? FILL_W'(MAX_PATTERN_BYTES) : v;
    endfunction

endpackage

// ===== hdl/bsfr_front.sv =====
// ---------------------------------------------------------------------------
// bsfr_front
// Takes input bytes, keeps the unresolved window and the replacement count,
// and turns each byte into at most one output job for the queue.
// ---------------------------------------------------------------------------
module bsfr_front import bsfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    input  logic       i_q_full,
    output logic       o_q_wr,
    output t_cmd       o_q_cmd,
    output t_fr_stat   o_stat
);

    t_win               r_win,  n_win;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [COUNT_W-1:0] r_done, n_done;

    t_win              w_app, w_pop;
    logic [FILL_W-1:0] f_app, slen, rlen, diff;
    logic [1:0]        pop_n;
    logic              match, allowed, hit, accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_stat.fill = r_fill;

    always_comb begin
        slen = clamp_len(i_cfg.search_length);
        rlen = clamp_len(i_cfg.replacement_length);

        // append the new byte; a full window overwrites its newest slot
        w_app = r_win;
        if (r_fill < FILL_W'(MAX_PATTERN_BYTES)) begin
            w_app[r_fill[WIN_IDX_W-1:0]] = i_byte;
            f_app = r_fill + FILL_W'(1);
        end else begin
            w_app[MAX_PATTERN_BYTES-1] = i_byte;
            f_app = FILL_W'(MAX_PATTERN_BYTES);
        end

        match = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if ((FILL_W'(k) < slen) && (w_app[k] != i_cfg.search_pattern[8*k +: 8]))
                match = 1'b0;
        end

        allowed = (slen != '0) &&
                  (i_cfg.replace_limit[16] || (r_done < i_cfg.replace_limit[15:0]));

        hit  = 1'b0;
        diff = f_app - slen;
        if (f_app > slen) begin
            // overfull after a shorter pattern: drain up to two bytes
            pop_n = (diff > FILL_W'(2)) ? 2'd2 : diff[1:0];
        end else if (f_app == slen) begin
            hit   = allowed && match;
            pop_n = hit ? 2'd0 : 2'd1;
        end else begin
            pop_n = 2'd0;
        end

        case (pop_n)
            2'd0:    w_pop = w_app;
            2'd1:    w_pop = w_app >> 8;
            default: w_pop = w_app >> 16;
        endcase

        o_q_cmd.last = i_eos;
        if (hit) begin
            o_q_cmd.data = i_cfg.replacement_pattern;
            o_q_cmd.cnt  = rlen;
        end else begin
            o_q_cmd.data = w_app;
            o_q_cmd.cnt  = i_eos ? f_app : FILL_W'(pop_n);
        end
        o_q_wr = accept && ((o_q_cmd.cnt != '0) || i_eos);

        n_win  = w_pop;
        n_fill = hit ? '0 : (f_app - FILL_W'(pop_n));
        n_done = r_done;
        if (hit && (r_done != '1))
            n_done = r_done + COUNT_W'(1);
        if (i_eos) begin
            n_fill = '0;
            n_done = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_win <= n_win;
    end

endmodule

// ===== hdl/bsfr_queue.sv =====
// ---------------------------------------------------------------------------
// bsfr_queue
// Short register FIFO of output jobs between front and back.
// ---------------------------------------------------------------------------
module bsfr_queue import bsfr_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr)
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        if (do_rd)
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        if (do_wr && !do_rd)
            n_cnt = r_cnt + CNT_W'(1);
        else if (do_rd && !do_wr)
            n_cnt = r_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr)
            r_mem[r_wp] <= i_cmd;
    end

endmodule

// ===== hdl/bsfr_back.sv =====
// ---------------------------------------------------------------------------
// bsfr_back
// Serializes queued jobs into output items, one byte per transaction.
// ---------------------------------------------------------------------------
module bsfr_back import bsfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_flag,
    output logic       o_last
);

    logic              r_busy;
    t_win              r_data;
    logic [FILL_W-1:0] r_cnt;
    logic              r_last;
    logic              hs, final_item;

    assign hs         = r_busy && i_ready;
    assign final_item = (r_cnt <= FILL_W'(1));
    assign o_q_pop    = i_q_valid && (!r_busy || (hs && final_item));

    assign o_valid = r_busy;
    assign o_flag  = (r_cnt != '0);
    assign o_byte  = o_flag ? r_data[0] : 8'd0;
    assign o_last  = r_last && final_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_busy <= 1'b0;
        else if (o_q_pop)
            r_busy <= 1'b1;
        else if (hs && final_item)
            r_busy <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_cmd.data;
            r_cnt  <= i_q_cmd.cnt;
            r_last <= i_q_cmd.last;
        end else if (hs && !final_item) begin
            r_data <= r_data >> 8;
            r_cnt  <= r_cnt - FILL_W'(1);
        end
    end

endmodule

// ===== hdl/byte_stream_find_replace.sv =====
// ---------------------------------------------------------------------------
// byte_stream_find_replace
// Streaming find/replace of a configured byte pattern, up to a limit per string.
// ---------------------------------------------------------------------------
//  channel   direction  signals                         payload
//  s_axis    in         tvalid tready tdata[7:0] tlast  data_byte, end_of_string
//  m_axis    out        tvalid tready tdata[7:0] tuser  out_byte, out_valid, out_last
//                       tlast
//  cfg       in         valid ready index[2:0]          register write
//                       data[63:0]
//
// The front takes one byte per cycle while the job queue has room; a byte that
// yields output becomes one job of 1 to 8 output items (a bare end marker is
// one item), a byte that yields nothing queues no job. The back sends one item
// per cycle while m_axis_tready is high, and the queue (QUEUE_DEPTH jobs)
// absorbs the difference between bytes in and items out. The first item of a
// byte passes through the queue and the back registers before it is offered.
// Input stalls only while the queue is full. Output comes straight from back
// registers. Reset is synchronous, active low; cfg is always ready.
// ---------------------------------------------------------------------------
module byte_stream_find_replace import bsfr_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
    output logic [0:0]            m_axis_tuser,   // [0] out_valid
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_cmd     fq_cmd, qb_cmd;
    logic     fq_wr, q_full, qb_valid, qb_pop;
    t_fr_stat fr_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.search_pattern      <= '0;
            r_cfg.search_length       <= '0;
            r_cfg.replacement_pattern <= '0;
            r_cfg.replacement_length  <= '0;
            r_cfg.replace_limit       <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SEARCH_PATTERN:      r_cfg.search_pattern      <= i_cfg_data;
                CFG_SEARCH_LENGTH:       r_cfg.search_length       <= i_cfg_data[3:0];
                CFG_REPLACEMENT_PATTERN: r_cfg.replacement_pattern <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH:  r_cfg.replacement_length  <= i_cfg_data[3:0];
                CFG_REPLACE_LIMIT:       r_cfg.replace_limit       <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    bsfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .i_q_full (q_full),
        .o_q_wr   (fq_wr),
        .o_q_cmd  (fq_cmd),
        .o_stat   (fr_stat)
    );

    bsfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fq_wr),
        .i_cmd   (fq_cmd),
        .o_full  (q_full),
        .i_pop   (qb_pop),
        .o_valid (qb_valid),
        .o_cmd   (qb_cmd)
    );

    bsfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (qb_valid),
        .i_q_cmd   (qb_cmd),
        .o_q_pop   (qb_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_flag    (m_axis_tuser[0]),
        .o_last    (m_axis_tlast)
    );

    // a bare end marker only ever closes a string
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
        else $error("bare marker without tlast or with data");

    // the window never holds more than the pattern size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_stat.fill <= FILL_W'(MAX_PATTERN_BYTES))
        else $error("window overfilled");

    // the last byte of a string empties the window
    a_eos_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (fr_stat.fill == '0))
        else $error("window not flushed at end of string");

endmodule
